// File: hdl/bes_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cubic Bezier easing solver.
// Used by the channel interfaces, the controller, the datapath and the top level.
package bes_pkg;

  // Width of every input and output field (unsigned Q1.16, 65536 = 1.0).
  localparam int FIELD_W = 17;
  localparam int FIELD_FRAC = 16;
  localparam logic [FIELD_W-1:0] OUT_MAX = 17'h10000;

  typedef enum logic [4:0] {
    S_IDLE,
    S_T2,
    S_T3,
    S_FA,
    S_FB,
    S_FC,
    S_FD,
    S_CHK,
    S_YT2,
    S_YT3,
    S_YR2,
    S_YU,
    S_YV,
    S_YW,
    S_YX,
    S_YS,
    S_OUT
  } state_t;

  // Operand pairs for the shared multiplier.
  typedef enum logic [3:0] {
    MS_TT,
    MS_T2T,
    MS_K0T3,
    MS_K1T2,
    MS_K2T,
    MS_RR,
    MS_T2R,
    MS_PY2,
    MS_TR2,
    MS_PY1
  } mul_sel_t;

  // Register that takes the scaled product.
  typedef enum logic [2:0] {
    DST_NONE,
    DST_T2,
    DST_T3,
    DST_P,
    DST_R2
  } dest_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_P_MINUS_X,
    ACC_ADD_P,
    ACC_T3_PLUS_3P,
    ACC_ADD_3P
  } acc_op_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    dest_t    dest;
    acc_op_t  acc_op;
    logic     r_load;
    logic     step;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic diag;
    logic f_small;
  } dp_stat_t;

endpackage

// File: hdl/bes_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the easing solver's input and result beats.
// Depends on bes_pkg for the field width.

interface bes_in_if;
  logic                         valid;
  logic                         ready;
  logic [bes_pkg::FIELD_W-1:0]  progress;
  logic [bes_pkg::FIELD_W-1:0]  first_ctrl_x;
  logic [bes_pkg::FIELD_W-1:0]  first_ctrl_y;
  logic [bes_pkg::FIELD_W-1:0]  second_ctrl_x;
  logic [bes_pkg::FIELD_W-1:0]  second_ctrl_y;

  modport source (
    output valid, progress, first_ctrl_x, first_ctrl_y, second_ctrl_x, second_ctrl_y,
    input  ready
  );
  modport sink (
    input  valid, progress, first_ctrl_x, first_ctrl_y, second_ctrl_x, second_ctrl_y,
    output ready
  );
endinterface

interface bes_out_if;
  logic                         valid;
  logic                         ready;
  logic [bes_pkg::FIELD_W-1:0]  eased_value;

  modport source (output valid, eased_value, input ready);
  modport sink (input valid, eased_value, output ready);
endinterface

// File: hdl/bes_dpath.sv
`timescale 1ns / 1ps
// Datapath of the easing solver: operand registers, one shared fixed-point
// multiplier, the accumulator, the parameter update and the result register.
// Depends on bes_pkg; driven by bes_ctrl through dp_cmd_t.
module bes_dpath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic [bes_pkg::FIELD_W-1:0]  progress,
  input  logic [bes_pkg::FIELD_W-1:0]  first_ctrl_x,
  input  logic [bes_pkg::FIELD_W-1:0]  first_ctrl_y,
  input  logic [bes_pkg::FIELD_W-1:0]  second_ctrl_x,
  input  logic [bes_pkg::FIELD_W-1:0]  second_ctrl_y,
  input  bes_pkg::dp_cmd_t             cmd,
  output bes_pkg::dp_stat_t            stat,
  output logic [bes_pkg::FIELD_W-1:0]  eased_value
);

  // Eleven integer bits and a sign cover every intermediate value: t is kept
  // within +/-4.0, so no sum or product exceeds about 1200.0.
  localparam int W   = FRAC_BITS + 12;
  localparam int SHL = (FRAC_BITS >= bes_pkg::FIELD_FRAC) ? FRAC_BITS - bes_pkg::FIELD_FRAC : 0;
  localparam int SHR = (FRAC_BITS <  bes_pkg::FIELD_FRAC) ? bes_pkg::FIELD_FRAC - FRAC_BITS : 0;
  localparam int EW  = W + SHR;

  localparam logic signed [W-1:0] ONE  = W'(64'd1 << FRAC_BITS);
  localparam logic signed [W-1:0] TLIM = W'(64'd4 << FRAC_BITS);
  localparam logic signed [W-1:0] EPS  = W'(((64'd5 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic signed [EW-1:0] OUT_MAX_S = $signed(EW'(bes_pkg::OUT_MAX));

  logic [bes_pkg::FIELD_W-1:0] px_r;
  logic                        diag_r;
  logic signed [W-1:0] x_r, k0_r, k1_r, k2_r, y1_r, y2_r;
  logic signed [W-1:0] t_r, t2_r, t3_r, r_r, r2_r, p_r, acc_r;
  logic signed [W-1:0] x_in, x1_in, y1_in, x2_in, y2_in;
  logic signed [W-1:0] op_a, op_b, mul_q;
  logic signed [2*W-1:0] prod;
  logic signed [W-1:0] acc_nxt, t_nxt, t_sub;
  logic signed [EW-1:0] y_ext;
  logic [bes_pkg::FIELD_W-1:0] out_nxt;
  logic [bes_pkg::FIELD_W-1:0] eased_r;

  function automatic logic signed [W-1:0] to_internal(input logic [bes_pkg::FIELD_W-1:0] v);
    logic [W-1:0] tmp;
    tmp = W'(v) << SHL;
    return $signed(tmp >> SHR);
  endfunction

  assign x_in  = to_internal(progress);
  assign x1_in = to_internal(first_ctrl_x);
  assign y1_in = to_internal(first_ctrl_y);
  assign x2_in = to_internal(second_ctrl_x);
  assign y2_in = to_internal(second_ctrl_y);

  assign stat.diag    = (first_ctrl_x == first_ctrl_y) && (second_ctrl_x == second_ctrl_y);
  assign stat.f_small = (acc_r <= EPS) && (acc_r >= -EPS);

  always_comb begin
    op_a = t_r;
    op_b = t_r;
    case (cmd.mul_sel)
      bes_pkg::MS_TT:   begin op_a = t_r;  op_b = t_r;  end
      bes_pkg::MS_T2T:  begin op_a = t2_r; op_b = t_r;  end
      bes_pkg::MS_K0T3: begin op_a = k0_r; op_b = t3_r; end
      bes_pkg::MS_K1T2: begin op_a = k1_r; op_b = t2_r; end
      bes_pkg::MS_K2T:  begin op_a = k2_r; op_b = t_r;  end
      bes_pkg::MS_RR:   begin op_a = r_r;  op_b = r_r;  end
      bes_pkg::MS_T2R:  begin op_a = t2_r; op_b = r_r;  end
      bes_pkg::MS_PY2:  begin op_a = p_r;  op_b = y2_r; end
      bes_pkg::MS_TR2:  begin op_a = t_r;  op_b = r2_r; end
      bes_pkg::MS_PY1:  begin op_a = p_r;  op_b = y1_r; end
      default:          begin op_a = t_r;  op_b = t_r;  end
    endcase
  end

  // Taking the bits above the fraction is a floor division by 2^FRAC_BITS.
  assign prod  = op_a * op_b;
  assign mul_q = prod[FRAC_BITS+W-1:FRAC_BITS];

  always_comb begin
    acc_nxt = acc_r;
    case (cmd.acc_op)
      bes_pkg::ACC_NONE:       acc_nxt = acc_r;
      bes_pkg::ACC_P_MINUS_X:  acc_nxt = p_r - x_r;
      bes_pkg::ACC_ADD_P:      acc_nxt = acc_r + p_r;
      bes_pkg::ACC_T3_PLUS_3P: acc_nxt = t3_r + p_r + (p_r <<< 1);
      bes_pkg::ACC_ADD_3P:     acc_nxt = acc_r + p_r + (p_r <<< 1);
      default:                 acc_nxt = acc_r;
    endcase
  end

  // Half-step correction of t, then clamp to +/-4.0.
  always_comb begin
    t_sub = t_r - (acc_r >>> 1);
    if (t_sub > TLIM) begin
      t_nxt = TLIM;
    end else if (t_sub < -TLIM) begin
      t_nxt = -TLIM;
    end else begin
      t_nxt = t_sub;
    end
  end

  always_comb begin
    y_ext = (EW'(acc_r) >>> SHL) <<< SHR;
    if (diag_r) begin
      out_nxt = (px_r > bes_pkg::OUT_MAX) ? bes_pkg::OUT_MAX : px_r;
    end else if (y_ext < 0) begin
      out_nxt = '0;
    end else if (y_ext > OUT_MAX_S) begin
      out_nxt = bes_pkg::OUT_MAX;
    end else begin
      out_nxt = y_ext[bes_pkg::FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r   <= progress;
      diag_r <= stat.diag;
      x_r    <= x_in;
      y1_r   <= y1_in;
      y2_r   <= y2_in;
      k0_r   <= ONE + x1_in + (x1_in <<< 1) - x2_in - (x2_in <<< 1);
      k1_r   <= x2_in + (x2_in <<< 1) - (x1_in <<< 1) - (x1_in <<< 2);
      k2_r   <= x1_in + (x1_in <<< 1);
      t_r    <= x_in;
    end else if (cmd.step) begin
      t_r <= t_nxt;
    end
    case (cmd.dest)
      bes_pkg::DST_NONE: ;
      bes_pkg::DST_T2:   t2_r <= mul_q;
      bes_pkg::DST_T3:   t3_r <= mul_q;
      bes_pkg::DST_P:    p_r  <= mul_q;
      bes_pkg::DST_R2:   r2_r <= mul_q;
      default: ;
    endcase
    acc_r <= acc_nxt;
    if (cmd.r_load) begin
      r_r <= ONE - t_r;
    end
    if (cmd.out_load) begin
      eased_r <= out_nxt;
    end
  end

  assign eased_value = eased_r;

endmodule

// File: hdl/bes_ctrl.sv
`timescale 1ns / 1ps
// Controller of the easing solver: sequences the datapath through the solver
// iterations and the final curve evaluation, and owns both handshakes.
// Depends on bes_pkg.
module bes_ctrl #(
  parameter int MAX_ITERATIONS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bes_pkg::dp_stat_t  stat,
  output bes_pkg::dp_cmd_t   cmd
);

  localparam int IW = $clog2(MAX_ITERATIONS + 1);
  localparam logic [IW-1:0] ITER_LAST = IW'(MAX_ITERATIONS - 1);

  bes_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]   iter_r, iter_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bes_pkg::S_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r;
    in_ready      = (state_r == bes_pkg::S_IDLE);
    cmd.load      = 1'b0;
    cmd.mul_sel   = bes_pkg::MS_TT;
    cmd.dest      = bes_pkg::DST_NONE;
    cmd.acc_op    = bes_pkg::ACC_NONE;
    cmd.r_load    = 1'b0;
    cmd.step      = 1'b0;
    cmd.out_load  = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bes_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          iter_nxt  = '0;
          state_nxt = stat.diag ? bes_pkg::S_OUT : bes_pkg::S_T2;
        end
      end
      bes_pkg::S_T2: begin
        cmd.mul_sel = bes_pkg::MS_TT;
        cmd.dest    = bes_pkg::DST_T2;
        state_nxt   = bes_pkg::S_T3;
      end
      bes_pkg::S_T3: begin
        cmd.mul_sel = bes_pkg::MS_T2T;
        cmd.dest    = bes_pkg::DST_T3;
        state_nxt   = bes_pkg::S_FA;
      end
      bes_pkg::S_FA: begin
        cmd.mul_sel = bes_pkg::MS_K0T3;
        cmd.dest    = bes_pkg::DST_P;
        state_nxt   = bes_pkg::S_FB;
      end
      bes_pkg::S_FB: begin
        cmd.acc_op  = bes_pkg::ACC_P_MINUS_X;
        cmd.mul_sel = bes_pkg::MS_K1T2;
        cmd.dest    = bes_pkg::DST_P;
        state_nxt   = bes_pkg::S_FC;
      end
      bes_pkg::S_FC: begin
        cmd.acc_op  = bes_pkg::ACC_ADD_P;
        cmd.mul_sel = bes_pkg::MS_K2T;
        cmd.dest    = bes_pkg::DST_P;
        state_nxt   = bes_pkg::S_FD;
      end
      bes_pkg::S_FD: begin
        cmd.acc_op = bes_pkg::ACC_ADD_P;
        state_nxt  = bes_pkg::S_CHK;
      end
      bes_pkg::S_CHK: begin
        // The accumulator now holds the residual of the curve equation.
        if (stat.f_small) begin
          state_nxt = bes_pkg::S_YT2;
        end else begin
          cmd.step = 1'b1;
          if (iter_r == ITER_LAST) begin
            state_nxt = bes_pkg::S_YT2;
          end else begin
            iter_nxt  = iter_r + 1'b1;
            state_nxt = bes_pkg::S_T2;
          end
        end
      end
      bes_pkg::S_YT2: begin
        cmd.mul_sel = bes_pkg::MS_TT;
        cmd.dest    = bes_pkg::DST_T2;
        cmd.r_load  = 1'b1;
        state_nxt   = bes_pkg::S_YT3;
      end
      bes_pkg::S_YT3: begin
        cmd.mul_sel = bes_pkg::MS_T2T;
        cmd.dest    = bes_pkg::DST_T3;
        state_nxt   = bes_pkg::S_YR2;
      end
      bes_pkg::S_YR2: begin
        cmd.mul_sel = bes_pkg::MS_RR;
        cmd.dest    = bes_pkg::DST_R2;
        state_nxt   = bes_pkg::S_YU;
      end
      bes_pkg::S_YU: begin
        cmd.mul_sel = bes_pkg::MS_T2R;
        cmd.dest    = bes_pkg::DST_P;
        state_nxt   = bes_pkg::S_YV;
      end
      bes_pkg::S_YV: begin
        cmd.mul_sel = bes_pkg::MS_PY2;
        cmd.dest    = bes_pkg::DST_P;
        state_nxt   = bes_pkg::S_YW;
      end
      bes_pkg::S_YW: begin
        cmd.acc_op  = bes_pkg::ACC_T3_PLUS_3P;
        cmd.mul_sel = bes_pkg::MS_TR2;
        cmd.dest    = bes_pkg::DST_P;
        state_nxt   = bes_pkg::S_YX;
      end
      bes_pkg::S_YX: begin
        cmd.mul_sel = bes_pkg::MS_PY1;
        cmd.dest    = bes_pkg::DST_P;
        state_nxt   = bes_pkg::S_YS;
      end
      bes_pkg::S_YS: begin
        cmd.acc_op = bes_pkg::ACC_ADD_3P;
        state_nxt  = bes_pkg::S_OUT;
      end
      bes_pkg::S_OUT: begin
        // Hold here only while an earlier result beat is still unclaimed.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bes_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bes_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/bezier_ease_solver.sv
`timescale 1ns / 1ps
// Cubic Bezier easing solver: maps a progress value through a timing curve
// given by two control points. Depends on bes_pkg, bes_if, bes_ctrl, bes_dpath.
//
// One item is worked on at a time on a single shared multiplier. Each solver
// iteration forms five products for the powers and coefficient terms of the
// residual, then accumulates the residual and checks it; after the last check
// the curve is evaluated at the final parameter. The item is accepted in the
// idle state and the result register is loaded in the output state. An item
// is resolved after 1 to MAX_ITERATIONS residual checks. When both control
// points lie on the diagonal the progress value goes from acceptance straight
// to the result register. The result register lets the next beat be accepted
// while the previous result still waits to be taken.
module bezier_ease_solver #(
  parameter int MAX_ITERATIONS = 12,
  parameter int FRAC_BITS      = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  bes_in_if.sink     in_ch,
  bes_out_if.source  out_ch
);

  bes_pkg::dp_cmd_t  cmd;
  bes_pkg::dp_stat_t stat;

  bes_ctrl #(
    .MAX_ITERATIONS(MAX_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bes_dpath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dpath (
    .clk           (clk),
    .progress      (in_ch.progress),
    .first_ctrl_x  (in_ch.first_ctrl_x),
    .first_ctrl_y  (in_ch.first_ctrl_y),
    .second_ctrl_x (in_ch.second_ctrl_x),
    .second_ctrl_y (in_ch.second_ctrl_y),
    .cmd           (cmd),
    .stat          (stat),
    .eased_value   (out_ch.eased_value)
  );

endmodule
